@@ design/first_fit_heap_allocator_defines.svh @@
// Assertion macros for the heap allocator.
// Each expects clk and rst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ffha_pkg.sv @@
package ffha_pkg;

  localparam int HEAP_UNITS   = 4096;
  localparam int UNIT_BYTES   = 8;
  localparam int HEADER_UNITS = 2;

  localparam int UNIT_W  = $clog2(HEAP_UNITS);       // index into the heap
  localparam int SIZE_W  = UNIT_W + 1;               // block size, holds HEAP_UNITS
  localparam int MARK_W  = 2;
  localparam int WORD_W  = MARK_W + SIZE_W;
  localparam int REQ_W   = 16;
  localparam int ADDR_W  = 15;
  localparam int LIMIT_W = 15;
  localparam int OFS_W   = $clog2(UNIT_BYTES);

  localparam int HDR_BYTES = HEADER_UNITS * UNIT_BYTES;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8176);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SIZE    = 2'd1,
    ST_OOM     = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [MARK_W-1:0] {
    MARK_NONE = 2'd0,
    MARK_FREE = 2'd1,
    MARK_USED = 2'd2,
    MARK_RSVD = 2'd3
  } mark_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

endpackage

@@ design/ffha_req_if.sv @@
interface ffha_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ffha_pkg::REQ_W-1:0]   request_bytes;
  logic [ffha_pkg::ADDR_W-1:0]  free_address;
  logic                         free_is_null;

  modport source (output valid, kind, request_bytes, free_address, free_is_null,
                  input ready);
  modport sink   (input valid, kind, request_bytes, free_address, free_is_null,
                  output ready);
endinterface

@@ design/ffha_rsp_if.sv @@
interface ffha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ffha_pkg::ADDR_W-1:0]  data_address;

  modport source (output valid, status, data_address, input ready);
  modport sink   (input valid, status, data_address, output ready);
endinterface

@@ design/first_fit_heap_allocator.sv @@
// First-fit heap allocator over an implicit block list. The heap is 4096 units
// of 8 bytes; each block starts with a 2-unit header recording its size and a
// free/allocated mark, held together in one 4096 x 15 single-port-write RAM
// with a registered read. After reset a clearing pass over all 4096 units
// initialises the RAM and no request is taken until it ends (cfg writes are
// taken throughout). Each request gives exactly one response. An allocate
// walks the blocks from unit 0, one header read per cycle, visiting more as
// fragmentation grows; a split adds a write of the back block header. A free
// reads the header, then checks its mark and writes it back; a rejected
// request goes straight to the hand-off. One request is in flight at a time;
// a finished response sits in an output register so the next request may
// start while it waits. Free blocks are never merged.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  ffha_req_if.sink                    in_req,
  ffha_rsp_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [ffha_pkg::LIMIT_W-1:0] cfg_wdata
);
  import ffha_pkg::*;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,  // clearing pass after reset
    S_IDLE  = 8'b0000_0010,
    S_FRD   = 8'b0000_0100,  // free: read header
    S_FCHK  = 8'b0000_1000,  // free: check mark, write back
    S_WRD   = 8'b0001_0000,  // alloc: read unit 0
    S_WCHK  = 8'b0010_0000,  // alloc: one hop per cycle
    S_WBACK = 8'b0100_0000,  // alloc: write header of split-off back block
    S_FIN   = 8'b1000_0000   // hand result to output register
  } state_t;

  // Header RAM: {mark, size}
  logic [WORD_W-1:0] hdr_mem [HEAP_UNITS];
  logic              wr_en;
  logic [UNIT_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [UNIT_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_q;

  state_t              state_r, state_nxt;
  logic [UNIT_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [UNIT_W-1:0]   pos_r, pos_nxt;
  logic [SIZE_W-1:0]   need_r, need_nxt;
  logic [SIZE_W-1:0]   front_r, front_nxt;
  logic                started_r, started_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  status_t             res_st_r, res_st_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_st_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic                accept;
  logic                load_out;
  mark_t               rd_mark;
  logic [SIZE_W-1:0]   rd_size;
  logic [REQ_W:0]      need_sum;
  logic [SIZE_W-1:0]   need_w;
  logic [SIZE_W-1:0]   hop_nxt;
  logic [SIZE_W-1:0]   back_unit;
  logic [ADDR_W-1:0]   free_ofs;
  logic [UNIT_W-1:0]   free_unit;

  // data byte offset just past the header at unit u
  function automatic logic [ADDR_W-1:0] data_ofs(input logic [SIZE_W-1:0] u);
    logic [SIZE_W-1:0]       hu;
    logic [SIZE_W+OFS_W-1:0] b;
    hu = u + SIZE_W'(HEADER_UNITS);
    b  = {hu, {OFS_W{1'b0}}};
    return b[ADDR_W-1:0];
  endfunction

  assign rd_mark = mark_t'(rd_q[WORD_W-1 -: MARK_W]);
  assign rd_size = rd_q[SIZE_W-1:0];

  // need = ceil((bytes + header bytes) / unit bytes); bytes <= limit keeps it in range
  assign need_sum = {1'b0, in_req.request_bytes} + (REQ_W+1)'(HDR_BYTES + UNIT_BYTES - 1);
  assign need_w   = SIZE_W'(need_sum >> OFS_W);

  assign hop_nxt   = {1'b0, pos_r} + rd_size;
  assign back_unit = {1'b0, pos_r} + front_r;

  // the largest 15-bit offset still maps below the heap end
  assign free_ofs  = in_req.free_address - ADDR_W'(HDR_BYTES);
  assign free_unit = UNIT_W'(free_ofs >> OFS_W);

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign load_out     = (state_r == S_FIN) && (!out_valid_r || out_rsp.ready);

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_st_r;
  assign out_rsp.data_address = out_addr_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pos_nxt       = pos_r;
    need_nxt      = need_r;
    front_nxt     = front_r;
    started_nxt   = started_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = '0;
    rd_addr       = pos_r;

    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = (clr_cnt_r == '0) ? {MARK_FREE, SIZE_W'(HEAP_UNITS)}
                                        : {MARK_NONE, {SIZE_W{1'b0}}};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {UNIT_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_addr_nxt = '0;
          if (in_req.kind == KIND_ALLOC) begin
            if (in_req.request_bytes == '0 ||
                in_req.request_bytes > {1'b0, limit_r}) begin
              res_st_nxt = ST_SIZE;
              state_nxt  = S_FIN;
            end else begin
              need_nxt    = need_w;
              started_nxt = 1'b1;
              pos_nxt     = '0;
              state_nxt   = S_WRD;
            end
          end else if (in_req.free_is_null) begin
            res_st_nxt = ST_OK;
            state_nxt  = S_FIN;
          end else if (!started_r ||
                       in_req.free_address < ADDR_W'(HDR_BYTES) ||
                       in_req.free_address[OFS_W-1:0] != '0) begin
            res_st_nxt = ST_BADFREE;
            state_nxt  = S_FIN;
          end else begin
            pos_nxt   = free_unit;
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (rd_mark == MARK_USED) begin
          wr_en      = 1'b1;
          wr_data    = {MARK_FREE, rd_size};
          res_st_nxt = ST_OK;
        end else begin
          res_st_nxt = ST_BADFREE;
        end
        state_nxt = S_FIN;
      end
      S_WRD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (rd_mark == MARK_FREE && rd_size >= need_r) begin
          // first fit found at pos_r
          if ({1'b0, rd_size} >= {1'b0, need_r} + (SIZE_W+1)'(2*HEADER_UNITS + 1)) begin
            front_nxt = rd_size - need_r - SIZE_W'(HEADER_UNITS);
            wr_en     = 1'b1;
            wr_data   = {MARK_FREE, front_nxt};
            state_nxt = S_WBACK;
          end else begin
            wr_en        = 1'b1;
            wr_data      = {MARK_USED, rd_size};
            res_st_nxt   = ST_OK;
            res_addr_nxt = data_ofs({1'b0, pos_r});
            state_nxt    = S_FIN;
          end
        end else if (rd_size == '0 || hop_nxt[SIZE_W-1]) begin
          // broken chain or end of heap
          res_st_nxt = ST_OOM;
          state_nxt  = S_FIN;
        end else begin
          pos_nxt = hop_nxt[UNIT_W-1:0];
          rd_addr = hop_nxt[UNIT_W-1:0];
        end
      end
      S_WBACK: begin
        // back block lies inside the old one, so it is below the heap end
        wr_en        = 1'b1;
        wr_addr      = back_unit[UNIT_W-1:0];
        wr_data      = {MARK_USED, need_r + SIZE_W'(HEADER_UNITS)};
        res_st_nxt   = ST_OK;
        res_addr_nxt = data_ofs(back_unit);
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    rd_q <= hdr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      started_r   <= 1'b0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    need_r     <= need_nxt;
    front_r    <= front_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    if (load_out) begin
      out_st_r   <= res_st_r;
      out_addr_r <= res_addr_r;
    end
  end

  `FFHA_ASSERT_NOW(a_no_req_in_clear, state_r == S_CLR, !in_req.ready, "request taken during clearing pass")
  `FFHA_ASSERT_NOW(a_addr_only_on_ok, out_rsp.valid && out_rsp.status != ST_OK, out_rsp.data_address == '0, "address on failed response")
  `FFHA_ASSERT_NOW(a_ok_addr_needs_start, out_rsp.valid && out_rsp.data_address != '0, started_r, "allocation before heap start")
  `FFHA_ASSERT_NEXT(a_fin_loads_out, load_out, out_rsp.valid && state_r == S_IDLE, "result not presented")

endmodule
